// ----- hdl/bilinear_heightmap_sampler_defines.svh -----
// assertion macros shared by the bilinear height-map sampler
// no dependencies; included by files that carry concurrent checks
`ifndef BILINEAR_HEIGHTMAP_SAMPLER_DEFINES_SVH
`define BILINEAR_HEIGHTMAP_SAMPLER_DEFINES_SVH

// condition must never hold outside reset
`define BHS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define BHS_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ----- hdl/bhs_pkg.sv -----
// shared constants, codes and stage structs of the bilinear height-map sampler
// no dependencies
package bhs_pkg;

    localparam int MAX_SIDE        = 256;
    localparam int SIDE_W          = $clog2(MAX_SIDE + 1);
    localparam int CELL_W          = $clog2(MAX_SIDE);
    localparam int STORE_DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = COORD_FRAC_BITS + 1;
    localparam int SAMPLE_W        = 8;
    localparam int HEIGHT_W        = 24;
    localparam int TAPS            = 4;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register indexes
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

    // neighbour taps
    localparam int TAP_LL = 0;
    localparam int TAP_LR = 1;
    localparam int TAP_HL = 2;
    localparam int TAP_HR = 3;

    // beat heading into the sample store
    typedef struct packed {
        logic                                valid;
        logic                                kind;
        logic [ADDR_W-1:0]                   waddr;
        logic [SAMPLE_W-1:0]                 wdata;
        logic [TAPS-1:0][ADDR_W-1:0]         raddr;
        logic [COORD_FRAC_BITS-1:0]          fx;
        logic [COORD_FRAC_BITS-1:0]          fy;
    } t_fetch;

    // four neighbours read back for one query
    typedef struct packed {
        logic                                valid;
        logic [TAPS-1:0][SAMPLE_W-1:0]       texel;
        logic [COORD_FRAC_BITS-1:0]          fx;
        logic [COORD_FRAC_BITS-1:0]          fy;
    } t_texels;

endpackage

// ----- hdl/bhs_regs.sv -----
// apb register file holding map width and height
// depends on bhs_pkg
module bhs_regs
    import bhs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [SIDE_W-1:0]  o_map_width,
    output logic [SIDE_W-1:0]  o_map_height
);

    logic [SIDE_W-1:0] r_map_width;
    logic [SIDE_W-1:0] r_map_height;
    logic              wr_beat;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_beat = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= SIDE_RESET;
            r_map_height <= SIDE_RESET;
        end else if (wr_beat) begin
            unique case (reg_sel)
                REG_MAP_WIDTH:  r_map_width  <= pwdata[SIDE_W-1:0];
                REG_MAP_HEIGHT: r_map_height <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            REG_MAP_WIDTH:  prdata = PDATA_W'(r_map_width);
            REG_MAP_HEIGHT: prdata = PDATA_W'(r_map_height);
            default:        prdata = '0;
        endcase
    end

    assign o_map_width  = r_map_width;
    assign o_map_height = r_map_height;

endmodule

// ----- hdl/bhs_addr.sv -----
// coordinate scaling and neighbour address generation, three register stages
// depends on bhs_pkg
module bhs_addr
    import bhs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat,
    input  logic                i_kind,
    input  logic [ADDR_W-1:0]   i_sample_index,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    input  logic [SIDE_W-1:0]   i_map_width,
    input  logic [SIDE_W-1:0]   i_map_height,
    output t_fetch              o_fetch
);

    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;
    localparam int SCALED_W = COORD_W + CELL_W;
    localparam int ROW_W    = SIDE_W + CELL_W;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        begin
            if (v < SIDE_W'(2))             r = SIDE_W'(2);
            else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
            else                            r = v;
            return r;
        end
    endfunction

    // stage 1: captured beat
    logic                       r_p1_valid;
    logic                       r_p1_kind;
    logic [ADDR_W-1:0]          r_p1_waddr;
    logic [SAMPLE_W-1:0]        r_p1_wdata;
    logic [COORD_W-1:0]         r_p1_cx;
    logic [COORD_W-1:0]         r_p1_cy;

    // stage 2: cells and fractions
    logic                       r_p2_valid;
    logic                       r_p2_kind;
    logic [ADDR_W-1:0]          r_p2_waddr;
    logic [SAMPLE_W-1:0]        r_p2_wdata;
    logic [CELL_W-1:0]          r_p2_lx, r_p2_hx, r_p2_ly, r_p2_hy;
    logic [COORD_FRAC_BITS-1:0] r_p2_fx, r_p2_fy;

    t_fetch                     r_fetch;

    logic [SIDE_W-1:0]          side_w, side_h;
    logic [CELL_W-1:0]          wm1, hm1;
    logic [COORD_W-1:0]         cx_sat, cy_sat;
    logic [SCALED_W-1:0]        scaled_x, scaled_y;
    logic [CELL_W-1:0]          n_lx, n_ly, n_hx, n_hy;
    logic [ROW_W-1:0]           row_lo, row_hi;

    assign side_w = clamp_side(i_map_width);
    assign side_h = clamp_side(i_map_height);
    assign wm1    = CELL_W'(side_w - SIDE_W'(1));
    assign hm1    = CELL_W'(side_h - SIDE_W'(1));

    // saturate and scale by side minus one
    assign cx_sat   = (r_p1_cx > COORD_ONE) ? COORD_ONE : r_p1_cx;
    assign cy_sat   = (r_p1_cy > COORD_ONE) ? COORD_ONE : r_p1_cy;
    assign scaled_x = SCALED_W'(cx_sat) * SCALED_W'(wm1);
    assign scaled_y = SCALED_W'(cy_sat) * SCALED_W'(hm1);
    assign n_lx     = scaled_x[COORD_FRAC_BITS +: CELL_W];
    assign n_ly     = scaled_y[COORD_FRAC_BITS +: CELL_W];
    assign n_hx     = (n_lx == wm1) ? n_lx : n_lx + CELL_W'(1);
    assign n_hy     = (n_ly == hm1) ? n_ly : n_ly + CELL_W'(1);

    // row bases
    assign row_lo = ROW_W'(side_w) * ROW_W'(r_p2_ly);
    assign row_hi = ROW_W'(side_w) * ROW_W'(r_p2_hy);

    // valid chain and payload stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid    <= 1'b0;
            r_p2_valid    <= 1'b0;
            r_fetch.valid <= 1'b0;
        end else begin
            r_p1_valid    <= i_beat;
            r_p2_valid    <= r_p1_valid;
            r_fetch.valid <= r_p2_valid;
        end

        r_p1_kind  <= i_kind;
        r_p1_waddr <= i_sample_index;
        r_p1_wdata <= i_sample_value;
        r_p1_cx    <= i_coord_x;
        r_p1_cy    <= i_coord_y;

        r_p2_kind  <= r_p1_kind;
        r_p2_waddr <= r_p1_waddr;
        r_p2_wdata <= r_p1_wdata;
        r_p2_lx    <= n_lx;
        r_p2_hx    <= n_hx;
        r_p2_ly    <= n_ly;
        r_p2_hy    <= n_hy;
        r_p2_fx    <= scaled_x[COORD_FRAC_BITS-1:0];
        r_p2_fy    <= scaled_y[COORD_FRAC_BITS-1:0];

        r_fetch.kind          <= r_p2_kind;
        r_fetch.waddr         <= r_p2_waddr;
        r_fetch.wdata         <= r_p2_wdata;
        r_fetch.raddr[TAP_LL] <= ADDR_W'(row_lo + ROW_W'(r_p2_lx));
        r_fetch.raddr[TAP_LR] <= ADDR_W'(row_lo + ROW_W'(r_p2_hx));
        r_fetch.raddr[TAP_HL] <= ADDR_W'(row_hi + ROW_W'(r_p2_lx));
        r_fetch.raddr[TAP_HR] <= ADDR_W'(row_hi + ROW_W'(r_p2_hx));
        r_fetch.fx            <= r_p2_fx;
        r_fetch.fy            <= r_p2_fy;
    end

    assign o_fetch = r_fetch;

endmodule

// ----- hdl/bhs_store.sv -----
// sample store: two copies written together, each read at two addresses per cycle
// depends on bhs_pkg
module bhs_store
    import bhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_fetch  i_fetch,
    output t_texels o_texels
);

    localparam int COPIES = TAPS / 2;

    logic                          wr_en;
    logic                          r_valid;
    logic [COORD_FRAC_BITS-1:0]    r_fx;
    logic [COORD_FRAC_BITS-1:0]    r_fy;
    logic [TAPS-1:0][SAMPLE_W-1:0] texel;

    // writes and reads share the same stage, so item order is kept
    assign wr_en = i_fetch.valid & (i_fetch.kind == KIND_WRITE);

    // copy 0 serves the low row, copy 1 the high row
    for (genvar r = 0; r < COPIES; r++) begin : g_rep
        logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
        logic [SAMPLE_W-1:0] r_rd_lo;
        logic [SAMPLE_W-1:0] r_rd_hi;
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[i_fetch.waddr] <= i_fetch.wdata;
            end
            r_rd_lo <= r_mem[i_fetch.raddr[2*r]];
            r_rd_hi <= r_mem[i_fetch.raddr[2*r+1]];
        end
        assign texel[2*r]   = r_rd_lo;
        assign texel[2*r+1] = r_rd_hi;
    end

    // query beat follows its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_fetch.valid & (i_fetch.kind == KIND_QUERY);
        end
        r_fx <= i_fetch.fx;
        r_fy <= i_fetch.fy;
    end

    assign o_texels = '{valid: r_valid, texel: texel, fx: r_fx, fy: r_fy};

endmodule

// ----- hdl/bhs_blend.sv -----
// bilinear blend: horizontal pass, then vertical pass with rounding
// depends on bhs_pkg
module bhs_blend
    import bhs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_texels             i_texels,
    output logic                o_valid,
    output logic [HEIGHT_W-1:0] o_height
);

    localparam int WGT_W = COORD_FRAC_BITS + 1;
    localparam int ROW_W = SAMPLE_W + COORD_FRAC_BITS;
    localparam int SUM_W = ROW_W + WGT_W;
    localparam logic [WGT_W-1:0] ONE  = WGT_W'(1) << COORD_FRAC_BITS;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (COORD_FRAC_BITS - 1);

    logic                       r_row_valid;
    logic [ROW_W-1:0]           r_top, r_bot;
    logic [COORD_FRAC_BITS-1:0] r_fy;
    logic                       r_valid;
    logic [HEIGHT_W-1:0]        r_height;

    logic [WGT_W-1:0]           wx0, wy0;
    logic [ROW_W-1:0]           n_top, n_bot;
    logic [SUM_W-1:0]           total;

    // horizontal blend
    assign wx0   = ONE - WGT_W'(i_texels.fx);
    assign n_top = ROW_W'(wx0) * ROW_W'(i_texels.texel[TAP_LL])
                 + ROW_W'(i_texels.fx) * ROW_W'(i_texels.texel[TAP_LR]);
    assign n_bot = ROW_W'(wx0) * ROW_W'(i_texels.texel[TAP_HL])
                 + ROW_W'(i_texels.fx) * ROW_W'(i_texels.texel[TAP_HR]);

    // vertical blend with round half up
    assign wy0   = ONE - WGT_W'(r_fy);
    assign total = SUM_W'(wy0) * SUM_W'(r_top) + SUM_W'(r_fy) * SUM_W'(r_bot) + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_row_valid <= i_texels.valid;
            r_valid     <= r_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_bot    <= n_bot;
        r_fy     <= i_texels.fy;
        r_height <= total[COORD_FRAC_BITS +: HEIGHT_W];
    end

    assign o_valid  = r_valid;
    assign o_height = r_height;

endmodule

// ----- hdl/bilinear_heightmap_sampler.sv -----
// Bilinear height-map sampler. One item is taken every clock (busy stays low);
// a write stores one 8-bit sample, a query returns the rounded bilinear height
// as a single-cycle strobe that cannot be held off. The result passes three
// address stages, the registered store read and two blend stages; the store is
// kept in two copies, one for the low row and one for the high row, each read
// at two addresses per cycle, so a query fetches all four neighbours at once.
// Writes and queries pass the store in order, so a query sees every write taken
// before it.
// depends on bhs_pkg, bhs_regs, bhs_addr, bhs_store, bhs_blend and the defines header
`include "bilinear_heightmap_sampler_defines.svh"

module bilinear_heightmap_sampler
    import bhs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [ADDR_W-1:0]   i_sample_index,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    output logic                o_height_valid,
    output logic [HEIGHT_W-1:0] o_height,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic              in_beat;
    logic [SIDE_W-1:0] map_width, map_height;
    t_fetch            fetch;
    t_texels           texels;

    // fully pipelined, never stalls
    assign busy    = 1'b0;
    assign in_beat = start & ~busy;

    bhs_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_map_width  (map_width),
        .o_map_height (map_height)
    );

    bhs_addr u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (in_beat),
        .i_kind         (i_kind),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_map_width    (map_width),
        .i_map_height   (map_height),
        .o_fetch        (fetch)
    );

    bhs_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fetch  (fetch),
        .o_texels (texels)
    );

    bhs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_texels (texels),
        .o_valid  (o_height_valid),
        .o_height (o_height)
    );

    // checks
    `BHS_ASSERT_DELAY(a_query_gives_result, i_clk, i_rst_n, in_beat && (i_kind == KIND_QUERY), 6, o_height_valid, "query beat lost")
    `BHS_ASSERT_DELAY(a_write_no_result, i_clk, i_rst_n, in_beat && (i_kind == KIND_WRITE), 6, !o_height_valid, "write beat gave a result")
    `BHS_ASSERT_NEVER(a_height_in_range, i_clk, i_rst_n, o_height_valid && (o_height > 24'hFF0000), "height above full scale")

endmodule

// ----- verif/bhs_checker.sv -----
`timescale 1ns / 1ps
// checker for the bilinear height-map sampler: checks each query height and each register read
// depends on bhs_pkg; watches the item, result and register channels beside the block
module bhs_checker
    import bhs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_kind,
    input  logic [ADDR_W-1:0]   i_sample_index,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    input  logic                i_height_valid,
    input  logic [HEIGHT_W-1:0] i_height,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0]  i_pwdata,
    input  logic [PDATA_W-1:0]  i_prdata,
    output int                  o_mismatches,
    output int                  o_pending
);

    localparam longint COORD_ONE = longint'(1) << COORD_FRAC_BITS;
    localparam logic [PADDR_W-1:0] ADDR_MAP_WIDTH  = PADDR_W'({REG_MAP_WIDTH, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_MAP_HEIGHT = PADDR_W'({REG_MAP_HEIGHT, 2'b00});

    // shadow of the sample store and of both size registers
    logic [SAMPLE_W-1:0] height_copy [STORE_DEPTH];
    logic [SIDE_W-1:0]   map_w_copy = SIDE_RESET;
    logic [SIDE_W-1:0]   map_h_copy = SIDE_RESET;

    // heights owed by queries already taken, oldest first
    logic [HEIGHT_W-1:0] owed_heights [$];
    int                  errors = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // size in use after clamping to 2..MAX_SIDE
    function automatic int used_side(input logic [SIDE_W-1:0] raw);
        if (raw < 2) return 2;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return int'(raw);
    endfunction

    // low cell, clamped high cell and blend weight along one axis
    function automatic void split_axis(input logic [COORD_W-1:0] c, input int side,
                                       output int lo, output int hi, output longint frac);
        longint sat;
        longint scaled;
        sat    = (longint'(c) > COORD_ONE) ? COORD_ONE : longint'(c);
        scaled = sat * longint'(side - 1);
        lo     = int'(scaled >> COORD_FRAC_BITS);
        frac   = scaled & (COORD_ONE - 1);
        if (lo > side - 1) lo = side - 1;
        hi = (lo + 1 > side - 1) ? side - 1 : lo + 1;
    endfunction

    // exact bilinear blend of four neighbours, rounded half up
    function automatic logic [HEIGHT_W-1:0] blend_height(input logic [COORD_W-1:0] cx,
                                                         input logic [COORD_W-1:0] cy);
        int     w, h, lx, hx, ly, hy;
        longint fx, fy, ll, lr, hl, hr, upper, lower, total;
        w = used_side(map_w_copy);
        h = used_side(map_h_copy);
        split_axis(cx, w, lx, hx, fx);
        split_axis(cy, h, ly, hy, fy);
        ll    = longint'(height_copy[w * ly + lx]);
        lr    = longint'(height_copy[w * ly + hx]);
        hl    = longint'(height_copy[w * hy + lx]);
        hr    = longint'(height_copy[w * hy + hx]);
        upper = (COORD_ONE - fx) * ll + fx * lr;
        lower = (COORD_ONE - fx) * hl + fx * hr;
        total = (COORD_ONE - fy) * upper + fy * lower;
        total = (total + (COORD_ONE >> 1)) >> COORD_FRAC_BITS;
        return HEIGHT_W'(total);
    endfunction

    // count a mismatch, report only the first few
    task automatic note_mismatch(input string what, input string want, input string got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d at %0t on %s: expected %s, got %s",
                     errors, $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        logic [HEIGHT_W-1:0] want;
        logic [SIDE_W-1:0]   reg_val;
        if (!i_rst_n) begin
            map_w_copy = SIDE_RESET;
            map_h_copy = SIDE_RESET;
            owed_heights.delete();
        end else begin
            // result beat against the oldest owed height
            if (i_height_valid) begin
                if (owed_heights.size() == 0) begin
                    note_mismatch("height", "no result", $sformatf("%0h", i_height));
                end else begin
                    want = owed_heights.pop_front();
                    if (i_height !== want)
                        note_mismatch("height", $sformatf("%0h", want),
                                      $sformatf("%0h", i_height));
                end
            end
            // register port: writes update the shadow, reads are compared
            if (i_psel && i_penable && i_pready) begin
                reg_val = (i_paddr == ADDR_MAP_HEIGHT) ? map_h_copy : map_w_copy;
                if (i_pwrite) begin
                    if (i_paddr == ADDR_MAP_WIDTH) map_w_copy = i_pwdata[SIDE_W-1:0];
                    else if (i_paddr == ADDR_MAP_HEIGHT) map_h_copy = i_pwdata[SIDE_W-1:0];
                end else if (i_paddr == ADDR_MAP_WIDTH || i_paddr == ADDR_MAP_HEIGHT) begin
                    if (i_prdata !== PDATA_W'(reg_val))
                        note_mismatch($sformatf("register read at %0h", i_paddr),
                                      $sformatf("%0h", reg_val), $sformatf("%0h", i_prdata));
                end
            end
            // item beat: store a sample or owe a height
            if (i_start && !i_busy) begin
                if (i_kind == KIND_WRITE) height_copy[i_sample_index] = i_sample_value;
                else owed_heights.insert(owed_heights.size(),
                                         blend_height(i_coord_x, i_coord_y));
            end
        end
        o_mismatches <= errors;
        o_pending    <= owed_heights.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the bilinear height-map sampler
// depends on bhs_pkg, bilinear_heightmap_sampler and bhs_checker
module testbench;
    import bhs_pkg::*;

    localparam int COORD_ONE   = 1 << COORD_FRAC_BITS;
    localparam int PHASE_ITEMS = 135;
    localparam int PHASES      = 10;
    localparam logic [PADDR_W-1:0] ADDR_MAP_WIDTH  = PADDR_W'({REG_MAP_WIDTH, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_MAP_HEIGHT = PADDR_W'({REG_MAP_HEIGHT, 2'b00});

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_kind;
    logic [ADDR_W-1:0]   i_sample_index;
    logic [SAMPLE_W-1:0] i_sample_value;
    logic [COORD_W-1:0]  i_coord_x;
    logic [COORD_W-1:0]  i_coord_y;
    logic                o_height_valid;
    logic [HEIGHT_W-1:0] o_height;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int mismatches;
    int pending;

    // entries written so far, so no query touches an undefined sample
    bit                sample_loaded [STORE_DEPTH];
    logic [SIDE_W-1:0] map_w;
    logic [SIDE_W-1:0] map_h;
    int                item_count = 0;
    bit                burst      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bilinear_heightmap_sampler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_height_valid (o_height_valid),
        .o_height       (o_height),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    bhs_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_height_valid (o_height_valid),
        .i_height       (o_height),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    function automatic int used_side(input logic [SIDE_W-1:0] raw);
        if (raw < 2) return 2;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return int'(raw);
    endfunction

    // neighbour cells a coordinate selects along one axis
    function automatic void cell_pair(input logic [COORD_W-1:0] c, input int side,
                                      output int lo, output int hi);
        longint sat;
        sat = (c > COORD_ONE) ? longint'(COORD_ONE) : longint'(c);
        lo  = int'((sat * longint'(side - 1)) >> COORD_FRAC_BITS);
        if (lo > side - 1) lo = side - 1;
        hi = (lo + 1 > side - 1) ? side - 1 : lo + 1;
    endfunction

    // heights lean toward the extremes
    function automatic logic [SAMPLE_W-1:0] random_height();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // coordinates: ends of the range, above one, and the inside
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_W'(COORD_ONE);
            2:       return COORD_W'($urandom_range(COORD_ONE + 1, (1 << COORD_W) - 1));
            default: return COORD_W'($urandom_range(0, COORD_ONE));
        endcase
    endfunction

    // one item beat, after a random gap unless in a burst
    task automatic issue_beat(input logic kind, input logic [ADDR_W-1:0] idx,
                              input logic [SAMPLE_W-1:0] value,
                              input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int gap;
        if ($urandom_range(0, 19) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_sample_index <= idx;
        i_sample_value <= value;
        i_coord_x      <= cx;
        i_coord_y      <= cy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == KIND_WRITE) sample_loaded[idx] = 1'b1;
        item_count++;
    endtask

    // write beat; the coordinate ports carry noise
    task automatic load_sample(input logic [ADDR_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
        issue_beat(KIND_WRITE, idx, value, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // query beat, preceded by writes of any neighbour not yet loaded
    task automatic sample_query(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int w, h, lx, hx, ly, hy;
        int taps [4];
        w = used_side(map_w);
        h = used_side(map_h);
        cell_pair(cx, w, lx, hx);
        cell_pair(cy, h, ly, hy);
        taps = '{w * ly + lx, w * ly + hx, w * hy + lx, w * hy + hx};
        foreach (taps[t])
            if (!sample_loaded[taps[t]]) load_sample(ADDR_W'(taps[t]), random_height());
        issue_beat(KIND_QUERY, ADDR_W'($urandom), SAMPLE_W'($urandom), cx, cy);
    endtask

    // one register transfer: setup, access, then bus idle
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [SIDE_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word               = PDATA_W'($urandom);
        word[SIDE_W-1:0]   = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop issuing and let every owed height and any trailing write drain out
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < 1000 && pending != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int                phase_w [PHASES];
        int                phase_h [PHASES];
        int                first_item;
        int                pick;
        int                area;
        phase_w = '{2, 0, 3, 511, 17, 256, 2, 257, 0, 0};
        phase_h = '{2, 1, 5, 300, 9, 2, 256, 255, 0, 0};

        start          <= 1'b0;
        i_kind         <= KIND_WRITE;
        i_sample_index <= '0;
        i_sample_value <= '0;
        i_coord_x      <= '0;
        i_coord_y      <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_rst_n        <= 1'b0;
        map_w = SIDE_RESET;
        map_h = SIDE_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both size registers
        reg_access(1'b0, ADDR_MAP_WIDTH, '0);
        reg_access(1'b0, ADDR_MAP_HEIGHT, '0);

        // directed: corners, far edges, saturation, half and near-one weights
        load_sample(ADDR_W'(0), '0);
        load_sample('1, '1);
        load_sample(ADDR_W'(1), '1);
        load_sample(ADDR_W'(MAX_SIDE), '1);
        sample_query('0, '0);
        sample_query(COORD_W'(COORD_ONE), COORD_W'(COORD_ONE));
        sample_query('1, '1);
        sample_query(COORD_W'(COORD_ONE), '0);
        sample_query('0, COORD_W'(COORD_ONE));
        sample_query(COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE / 2));
        sample_query(COORD_W'(COORD_ONE - 1), COORD_W'(COORD_ONE - 1));

        // random phases, each under its own map size
        for (int p = 0; p < PHASES; p++) begin
            if (p >= PHASES - 2) begin
                phase_w[p] = $urandom_range(0, (1 << SIDE_W) - 1);
                phase_h[p] = $urandom_range(0, (1 << SIDE_W) - 1);
            end
            settle();
            reg_access(1'b1, ADDR_MAP_WIDTH, SIDE_W'(phase_w[p]));
            reg_access(1'b1, ADDR_MAP_HEIGHT, SIDE_W'(phase_h[p]));
            reg_access(1'b0, ADDR_MAP_WIDTH, '0);
            reg_access(1'b0, ADDR_MAP_HEIGHT, '0);
            map_w = SIDE_W'(phase_w[p]);
            map_h = SIDE_W'(phase_h[p]);
            area  = used_side(map_w) * used_side(map_h);

            first_item = item_count;
            while (item_count - first_item < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) sample_query(random_coord(), random_coord());
                else if (pick < 85) load_sample(ADDR_W'($urandom_range(0, area - 1)),
                                                random_height());
                else load_sample(ADDR_W'($urandom), random_height());
            end
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
